FILE: rtl/core/sdtq_pkg.sv
// Package for the sorted deadline timer queue.
// Holds the command, result and status codes and the controller state type.
// Has no dependencies.
package sdtq_pkg;

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_DEL  = 2'd1,
        CMD_TICK = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_FIRE = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_DL   = 2'd1;
    localparam logic [1:0] ST_ACTIVE   = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_SCAN,
        S_ADD_WR,
        S_DEL_SCAN,
        S_DEL_SHIFT,
        S_TICK_CHK,
        S_TICK_RM,
        S_TICK_INS_SCAN,
        S_TICK_INS_WR,
        S_TICK_FIND,
        S_TICK_END,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic ins_write;
        logic rm_shift;
        logic tick_arm;
        logic tick_rm;
        logic tick_ins_start;
        logic find_start;
        logic emit_ack;
        logic emit_fire;
        logic emit_done;
        logic del_clear;
    } t_cmd_bus;

    typedef struct packed {
        logic scan_done;
        logic dl_zero;
        logic id_bad;
        logic full;
        logic active;
        logic del_hit;
        logic tick_go;
        logic tick_has_next;
        logic tick_more;
        logic tick_periodic;
        logic fire_emit;
        logic pos_zero;
        logic out_busy;
    } t_stat_bus;

endpackage

FILE: rtl/core/sdtq_datapath.sv
// Datapath of the sorted deadline timer queue: sorted list, slot tables,
// scan position, budget counter and the output register. Uses sdtq_pkg.
module sdtq_datapath import sdtq_pkg::*; #(
    parameter int NUM_TIMERS  = 16,
    parameter int MAX_ACTIONS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd_bus    i_ctl,
    output t_stat_bus   o_st,
    input  logic [1:0]  i_ack_status,
    input  logic        i_ack_prog,
    input  logic [31:0] i_min_period,
    input  logic [3:0]  i_timer_id,
    input  logic [63:0] i_deadline,
    input  logic        i_periodic,
    input  logic [63:0] i_period,
    input  logic [63:0] i_now,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_fired_id,
    output logic [1:0]  o_status,
    output logic        o_program_timer,
    output logic [63:0] o_next_deadline,
    output logic        o_last
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int BW = $clog2(MAX_ACTIONS + 1);

    logic [63:0]   r_odl [NUM_TIMERS];
    logic [IW-1:0] r_oslot [NUM_TIMERS];
    logic [63:0]   r_sper [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] r_speriodic, r_sactive;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_pos;
    logic [BW-1:0] r_tries;
    logic [5:0]    r_nout;
    logic [3:0]    r_id;
    logic [63:0]   r_dl, r_ins_dl, r_now, r_per;
    logic          r_per_en;
    logic [IW-1:0] r_ins_slot, r_nxt;
    logic          r_has_next;
    logic [63:0]   r_edl;

    logic [CW-1:0] w_cnt_m1;
    logic [IW-1:0] w_pidx, w_idx;
    logic          w_in_range, w_ok;
    logic [63:0]   w_head;
    logic [63:0]   w_per_sel;

    assign w_cnt_m1   = r_cnt - CW'(1);
    assign w_pidx     = r_pos[IW-1:0];
    assign w_in_range = (r_pos < r_cnt);
    assign w_idx      = IW'(r_id);
    assign w_ok       = ({28'd0, r_id} < 32'(NUM_TIMERS));
    assign w_per_sel  = (r_per_en && r_per < {32'd0, i_min_period}) ?
                        {32'd0, i_min_period} : r_per;

    always_comb begin
        o_st               = '0;
        o_st.dl_zero       = (r_dl == 64'd0);
        o_st.id_bad        = !w_ok;
        o_st.full          = (r_cnt >= CW'(NUM_TIMERS));
        o_st.active        = w_ok && r_sactive[w_idx];
        o_st.scan_done     = !w_in_range || (r_odl[w_pidx] >= r_ins_dl);
        o_st.del_hit       = w_in_range && ({{(32-IW){1'b0}}, r_oslot[w_pidx]}
                             == {28'd0, r_id});
        o_st.tick_go       = w_in_range && (r_odl[w_pidx] <= r_now) &&
                             (r_tries != BW'(1));
        o_st.tick_has_next = (r_pos + CW'(1)) < r_cnt;
        o_st.tick_more     = r_has_next;
        o_st.tick_periodic = r_speriodic[r_ins_slot];
        o_st.fire_emit     = (r_edl != 64'd0) &&
                             (r_nout < 6'(MAX_ACTIONS - 1));
        o_st.pos_zero      = (r_pos == '0);
        o_st.out_busy      = o_valid && !i_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_id     <= i_timer_id;
            r_dl     <= i_deadline;
            r_ins_dl <= i_deadline;
            r_ins_slot <= IW'(i_timer_id);
            r_per    <= i_period;
            r_per_en <= i_periodic;
            r_now    <= i_now;
            r_pos    <= '0;
            r_tries  <= BW'(MAX_ACTIONS);
            r_nout   <= '0;
        end
        if (i_ctl.scan_step) r_pos <= r_pos + CW'(1);
        if (i_ctl.ins_write) begin
            for (int k = NUM_TIMERS - 1; k > 0; k--) begin
                if (CW'(k) > r_pos && CW'(k) <= r_cnt) begin
                    r_odl[k]   <= r_odl[k-1];
                    r_oslot[k] <= r_oslot[k-1];
                end
            end
            r_odl[w_pidx]   <= r_ins_dl;
            r_oslot[w_pidx] <= r_ins_slot;
            if (!i_ctl.tick_arm) begin
                r_sper[r_ins_slot] <= w_per_sel;
            end
        end
        if (i_ctl.rm_shift) begin
            for (int k = 0; k < NUM_TIMERS - 1; k++) begin
                if (CW'(k) >= r_pos && CW'(k) < w_cnt_m1) begin
                    r_odl[k]   <= r_odl[k+1];
                    r_oslot[k] <= r_oslot[k+1];
                end
            end
        end
        if (i_ctl.tick_rm) begin
            r_edl      <= r_odl[w_pidx];
            r_ins_slot <= r_oslot[w_pidx];
            r_has_next <= o_st.tick_has_next;
            r_nxt      <= o_st.tick_has_next ? r_oslot[IW'(r_pos + CW'(1))] : '0;
            r_tries    <= r_tries - BW'(1);
        end
        if (i_ctl.tick_ins_start) begin
            r_ins_dl <= r_edl + r_sper[r_ins_slot];
            r_pos    <= '0;
        end
        if (i_ctl.find_start) begin
            r_pos <= '0;
            r_id  <= 4'(r_nxt);
        end
        if (i_ctl.emit_fire) r_nout <= r_nout + 6'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_sactive   <= '0;
            r_speriodic <= '0;
        end else begin
            if (i_ctl.ins_write) begin
                r_cnt <= r_cnt + CW'(1);
                r_sactive[r_ins_slot] <= 1'b1;
                if (!i_ctl.tick_arm) r_speriodic[r_ins_slot] <= r_per_en;
            end
            if (i_ctl.rm_shift) r_cnt <= w_cnt_m1;
            if (i_ctl.del_clear) r_sactive[w_idx] <= 1'b0;
            if (i_ctl.tick_rm) r_sactive[r_oslot[w_pidx]] <= 1'b0;
        end
    end

    assign w_head = (r_cnt != '0) ? r_odl[0] : 64'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_ctl.emit_ack || i_ctl.emit_fire || i_ctl.emit_done) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit_ack || i_ctl.emit_fire || i_ctl.emit_done) begin
            o_next_deadline <= w_head;
            o_last          <= !i_ctl.emit_fire;
            if (i_ctl.emit_ack) begin
                o_kind          <= KIND_ACK;
                o_fired_id      <= r_id;
                o_status        <= i_ack_status;
                o_program_timer <= i_ack_prog;
            end else if (i_ctl.emit_fire) begin
                o_kind          <= KIND_FIRE;
                o_fired_id      <= 4'(r_ins_slot);
                o_status        <= ST_OK;
                o_program_timer <= 1'b0;
            end else begin
                o_kind          <= KIND_DONE;
                o_fired_id      <= '0;
                o_status        <= ST_OK;
                o_program_timer <= (r_cnt != '0);
            end
        end
    end

endmodule

FILE: rtl/core/sdtq_ctrl.sv
// Controller state machine of the sorted deadline timer queue.
// Sequences add, delete and tick over the datapath. Uses sdtq_pkg.
module sdtq_ctrl import sdtq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  logic [1:0] i_cmd,
    input  t_stat_bus i_st,
    output t_cmd_bus  o_ctl,
    output logic [1:0] o_ack_status,
    output logic       o_ack_prog
);

    t_state r_state, n_state;
    logic [1:0] r_ast, n_ast;
    logic r_aprog, n_aprog;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ast   <= ST_OK;
            r_aprog <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ast   <= n_ast;
            r_aprog <= n_aprog;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ast   = r_ast;
        n_aprog = r_aprog;
        o_ctl   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = !i_st.out_busy;
                if (i_valid && o_ready) begin
                    o_ctl.load = 1'b1;
                    unique case (t_cmd'(i_cmd))
                        CMD_ADD:  n_state = S_ADD_SCAN;
                        CMD_DEL:  n_state = S_DEL_SCAN;
                        CMD_TICK: n_state = S_TICK_CHK;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_SCAN: begin
                if (i_st.dl_zero) begin
                    n_ast = ST_BAD_DL; n_aprog = 1'b0; n_state = S_OUT;
                end else if (i_st.id_bad || i_st.full) begin
                    n_ast = ST_FULL; n_aprog = 1'b0; n_state = S_OUT;
                end else if (i_st.active) begin
                    n_ast = ST_ACTIVE; n_aprog = 1'b0; n_state = S_OUT;
                end else if (i_st.scan_done) begin
                    n_state = S_ADD_WR;
                end else begin
                    o_ctl.scan_step = 1'b1;
                end
            end
            S_ADD_WR: begin
                o_ctl.ins_write = 1'b1;
                n_ast   = ST_OK;
                n_aprog = i_st.pos_zero;
                n_state = S_OUT;
            end
            S_DEL_SCAN: begin
                n_ast = ST_OK; n_aprog = 1'b0;
                if (!i_st.active) begin
                    n_state = S_OUT;
                end else if (i_st.del_hit) begin
                    n_state = S_DEL_SHIFT;
                end else begin
                    o_ctl.scan_step = 1'b1;
                end
            end
            S_DEL_SHIFT: begin
                o_ctl.rm_shift  = 1'b1;
                o_ctl.del_clear = 1'b1;
                n_state = S_OUT;
            end
            S_TICK_CHK: begin
                if (!i_st.out_busy) begin
                    if (i_st.tick_go) begin
                        o_ctl.tick_rm  = 1'b1;
                        o_ctl.rm_shift = 1'b1;
                        n_state = S_TICK_RM;
                    end else begin
                        o_ctl.emit_done = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_TICK_RM: begin
                if (i_st.tick_periodic) begin
                    o_ctl.tick_ins_start = 1'b1;
                    n_state = S_TICK_INS_SCAN;
                end else begin
                    n_state = S_TICK_INS_WR;
                end
            end
            S_TICK_INS_SCAN: begin
                if (i_st.scan_done) begin
                    o_ctl.ins_write = 1'b1;
                    o_ctl.tick_arm  = 1'b1;
                    n_state = S_TICK_INS_WR;
                end else begin
                    o_ctl.scan_step = 1'b1;
                end
            end
            S_TICK_INS_WR: begin
                if (!i_st.out_busy) begin
                    if (i_st.fire_emit) o_ctl.emit_fire = 1'b1;
                    if (i_st.tick_more) begin
                        o_ctl.find_start = 1'b1;
                        n_state = S_TICK_FIND;
                    end else begin
                        n_state = S_TICK_END;
                    end
                end
            end
            S_TICK_FIND: begin
                if (i_st.del_hit) begin
                    n_state = S_TICK_CHK;
                end else begin
                    o_ctl.scan_step = 1'b1;
                end
            end
            S_TICK_END: begin
                if (!i_st.out_busy) begin
                    o_ctl.emit_done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (!i_st.out_busy) begin
                    o_ctl.emit_ack = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ack_status = r_ast;
    assign o_ack_prog   = r_aprog;

endmodule

FILE: rtl/core/sorted_deadline_timer_queue.sv
// Channel   | Signals                                          | Direction
// in        | i_valid/o_ready, i_cmd ... i_now                  | to block
// out       | o_valid/i_ready, o_kind ... o_last                | from block
// cfg       | i_cfg_we, i_cfg_data (min_period)                 | to block
// The time from transfer to result of an add or delete is set by the
// list scan.
// A tick steps each fired entry through the check, remove and write
// states, with a scan to find the next entry and one more scan per re-arm.
// Reset clears the list count and slot flags; no clearing pass.
// A stalled output holds the controller; one result is in flight at a time.
// Top level of the sorted deadline timer queue. Uses sdtq_pkg,
// sdtq_ctrl and sdtq_datapath.
module sorted_deadline_timer_queue import sdtq_pkg::*; #(
    parameter int NUM_TIMERS  = 16,
    parameter int MAX_ACTIONS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [3:0]  i_timer_id,
    input  logic [63:0] i_deadline,
    input  logic        i_periodic,
    input  logic [63:0] i_period,
    input  logic [63:0] i_now,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_fired_id,
    output logic [1:0]  o_status,
    output logic        o_program_timer,
    output logic [63:0] o_next_deadline,
    output logic        o_last
);

    logic [31:0] r_min_period;
    t_cmd_bus    w_ctl;
    t_stat_bus   w_st;
    logic [1:0]  w_ast;
    logic        w_aprog;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_period <= '0;
        end else if (i_cfg_we) begin
            r_min_period <= i_cfg_data;
        end
    end

    sdtq_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_cmd,
        .i_st(w_st), .o_ctl(w_ctl),
        .o_ack_status(w_ast), .o_ack_prog(w_aprog)
    );

    sdtq_datapath #(.NUM_TIMERS(NUM_TIMERS), .MAX_ACTIONS(MAX_ACTIONS)) u_dp (
        .i_clk, .i_rst_n, .i_ctl(w_ctl), .o_st(w_st),
        .i_ack_status(w_ast), .i_ack_prog(w_aprog),
        .i_min_period(r_min_period), .i_timer_id, .i_deadline, .i_periodic,
        .i_period, .i_now, .o_valid, .i_ready, .o_kind, .o_fired_id,
        .o_status, .o_program_timer, .o_next_deadline, .o_last
    );

endmodule

FILE: rtl/core/sdtq_checker.sv
// Port-level checker for the sorted deadline timer queue, with its bind.
// Depends on the top level's ports and the codes in sdtq_pkg.
module sdtq_checker import sdtq_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_kind,
    input logic [1:0]  o_status,
    input logic        o_program_timer,
    input logic [63:0] o_next_deadline,
    input logic        o_last
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_next_deadline))
        else $error("result changed while stalled");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_kind != 2'd3) else $error("bad kind");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_FIRE |-> !o_last) else $error("fire marked last");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_DONE |-> o_last && o_status == ST_OK)
        else $error("tick finish not last or with status");
endmodule

bind sorted_deadline_timer_queue sdtq_checker u_chk (.*);

FILE: test/tb_sorted_deadline_timer_queue.sv
// Testbench for the sorted deadline timer queue: adds, deletes and ticks are
// checked against a behavioral timer list kept in the bench.
// Depends on sdtq_pkg and the sorted_deadline_timer_queue RTL.
`timescale 1ns / 100ps

module tb_sorted_deadline_timer_queue;
    import sdtq_pkg::*;

    localparam int NUM_TIMERS  = 16;
    localparam int MAX_ACTIONS = 32;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  fired_id;
        logic [1:0]  status;
        logic        program_timer;
        logic [63:0] next_deadline;
        logic        last;
    } t_timer_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_cmd;
    logic [3:0]  i_timer_id;
    logic [63:0] i_deadline;
    logic        i_periodic;
    logic [63:0] i_period;
    logic [63:0] i_now;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_kind;
    logic [3:0]  o_fired_id;
    logic [1:0]  o_status;
    logic        o_program_timer;
    logic [63:0] o_next_deadline;
    logic        o_last;

    sorted_deadline_timer_queue #(
        .NUM_TIMERS  (NUM_TIMERS),
        .MAX_ACTIONS (MAX_ACTIONS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (i_cmd),
        .i_timer_id      (i_timer_id),
        .i_deadline      (i_deadline),
        .i_periodic      (i_periodic),
        .i_period        (i_period),
        .i_now           (i_now),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_fired_id      (o_fired_id),
        .o_status        (o_status),
        .o_program_timer (o_program_timer),
        .o_next_deadline (o_next_deadline),
        .o_last          (o_last)
    );

    // Bench copy of the timer list.
    logic [63:0] list_dl [NUM_TIMERS];
    logic [3:0]  list_slot [NUM_TIMERS];
    int          list_count;
    logic [63:0] slot_period_q [NUM_TIMERS];
    logic        slot_periodic_q [NUM_TIMERS];
    logic        slot_active_q [NUM_TIMERS];
    logic [31:0] min_period_q;

    t_timer_result expected_results[$];
    int  error_count;
    int  idle_cycles;
    bit  stall_enable;

    initial begin
        i_clk = 1'b0;
        forever begin
            #4 i_clk = 1'b1;
            #4 i_clk = 1'b0;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [63:0] head_dl();
        return (list_count != 0) ? list_dl[0] : 64'd0;
    endfunction

    function automatic void list_remove(int pos);
        for (int j = pos; j < list_count - 1; j++) begin
            list_dl[j]   = list_dl[j + 1];
            list_slot[j] = list_slot[j + 1];
        end
        list_count--;
    endfunction

    function automatic int list_insert(logic [3:0] slot, logic [63:0] dl);
        int pos;
        pos = 0;
        while (pos < list_count && list_dl[pos] < dl) pos++;
        for (int j = list_count; j > pos; j--) begin
            list_dl[j]   = list_dl[j - 1];
            list_slot[j] = list_slot[j - 1];
        end
        list_dl[pos]   = dl;
        list_slot[pos] = slot;
        list_count++;
        return pos;
    endfunction

    function automatic int list_find(logic [3:0] slot);
        for (int j = 0; j < list_count; j++)
            if (list_slot[j] == slot) return j;
        return list_count;
    endfunction

    function automatic void push_result(logic [1:0] kind, logic [3:0] id, logic [1:0] status,
                                        logic prog, logic [63:0] nd);
        t_timer_result r;
        r.kind = kind;
        r.fired_id = id;
        r.status = status;
        r.program_timer = prog;
        r.next_deadline = nd;
        r.last = 1'b0;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_timer_op(t_cmd cmd, logic [3:0] id, logic [63:0] dl,
                                             logic per, logic [63:0] period,
                                             logic [63:0] now);
        logic [1:0]  status;
        logic        prog;
        int          n;
        int          tries;
        int          idx;
        logic [3:0]  s;
        logic [3:0]  nxt;
        logic        has_next;
        logic [63:0] edl;
        int          pos;
        n = 0;
        case (cmd)
            CMD_ADD: begin
                status = ST_OK;
                prog = 1'b0;
                if (dl == 64'd0) begin
                    status = ST_BAD_DL;
                end else if (list_count >= NUM_TIMERS) begin
                    status = ST_FULL;
                end else if (slot_active_q[id]) begin
                    status = ST_ACTIVE;
                end else begin
                    if (per && period < {32'd0, min_period_q}) period = {32'd0, min_period_q};
                    slot_period_q[id] = period;
                    slot_periodic_q[id] = per;
                    slot_active_q[id] = 1'b1;
                    pos = list_insert(id, dl);
                    prog = (pos == 0);
                end
                push_result(KIND_ACK, id, status, prog, head_dl());
                n = 1;
            end
            CMD_DEL: begin
                if (slot_active_q[id]) begin
                    list_remove(list_find(id));
                    slot_active_q[id] = 1'b0;
                end
                push_result(KIND_ACK, id, ST_OK, 1'b0, head_dl());
                n = 1;
            end
            CMD_TICK: begin
                tries = MAX_ACTIONS;
                idx = 0;
                while (idx < list_count) begin
                    s = list_slot[idx];
                    has_next = (idx + 1) < list_count;
                    nxt = has_next ? list_slot[idx + 1] : 4'd0;
                    edl = list_dl[idx];
                    tries--;
                    if (!(edl <= now && tries != 0)) break;
                    list_remove(idx);
                    slot_active_q[s] = 1'b0;
                    if (slot_periodic_q[s]) begin
                        pos = list_insert(s, edl + slot_period_q[s]);
                        slot_active_q[s] = 1'b1;
                    end
                    if (edl != 64'd0 && n < MAX_ACTIONS - 1) begin
                        push_result(KIND_FIRE, s, ST_OK, 1'b0, head_dl());
                        n++;
                    end
                    if (!has_next) break;
                    idx = list_find(nxt);
                end
                push_result(KIND_DONE, 4'd0, ST_OK, list_count != 0, head_dl());
                n++;
            end
            default: ;
        endcase
        if (n > 0) expected_results[$].last = 1'b1;
    endfunction

    task automatic send_timer_op(t_cmd cmd, logic [3:0] id, logic [63:0] dl, logic per,
                                 logic [63:0] period, logic [63:0] now);
        int gap;
        gap = stall_enable ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= cmd;
        i_timer_id <= id;
        i_deadline <= dl;
        i_periodic <= per;
        i_period   <= period;
        i_now      <= now;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_timer_op(cmd, id, dl, per, period, now);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (NUM_TIMERS * 4 + 20) @(posedge i_clk);
    endtask

    task automatic write_min_period(logic [31:0] value);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        min_period_q = value;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic test_directed_ops();
        send_timer_op(CMD_ADD, 4'd1, 64'd0, 1'b0, 64'd0, 64'd0);
        send_timer_op(CMD_ADD, 4'd2, 64'd100, 1'b0, 64'd0, 64'd0);
        send_timer_op(CMD_ADD, 4'd2, 64'd50, 1'b0, 64'd0, 64'd0);
        send_timer_op(CMD_ADD, 4'd3, 64'd100, 1'b1, 64'd5, 64'd0);
        send_timer_op(CMD_ADD, 4'd15, 64'd40, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
        send_timer_op(CMD_ADD, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0, 64'd0);
        send_timer_op(CMD_DEL, 4'd7, 64'd0, 1'b0, 64'd0, 64'd0);
        send_timer_op(CMD_DEL, 4'd0, 64'd0, 1'b0, 64'd0, 64'd0);
        send_timer_op(CMD_NONE, 4'd5, 64'd9, 1'b1, 64'd9, 64'd9);
        send_timer_op(CMD_TICK, 4'd0, 64'd0, 1'b0, 64'd0, 64'd99);
        send_timer_op(CMD_TICK, 4'd0, 64'd0, 1'b0, 64'd0, 64'd200);
        send_timer_op(CMD_TICK, 4'd0, 64'd0, 1'b0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFE);
        for (int k = 0; k < NUM_TIMERS; k++)
            send_timer_op(CMD_DEL, 4'(k), 64'd0, 1'b0, 64'd0, 64'd0);
    endtask

    task automatic test_full_table();
        for (int k = 0; k < NUM_TIMERS; k++)
            send_timer_op(CMD_ADD, 4'(k), 64'd10, 1'b1, 64'd1, 64'd0);
        send_timer_op(CMD_ADD, 4'd4, 64'd3, 1'b0, 64'd0, 64'd0);
        // Entries fire and re-arm in turn until the action budget runs out.
        send_timer_op(CMD_TICK, 4'd0, 64'd0, 1'b0, 64'd0, 64'd1000);
        for (int k = 0; k < NUM_TIMERS; k++)
            send_timer_op(CMD_DEL, 4'(k), 64'd0, 1'b0, 64'd0, 64'd0);
    endtask

    task automatic test_random_ops(int count);
        logic [63:0] base;
        int          roll;
        base = rand64() >> $urandom_range(0, 63);
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
                send_timer_op(CMD_ADD, 4'($urandom_range(0, 15)),
                              ($urandom_range(0, 19) == 0) ? 64'd0 :
                              (($urandom_range(0, 9) == 0) ? rand64() :
                               base + $urandom_range(0, 200)),
                              1'($urandom()),
                              ($urandom_range(0, 5) == 0) ? rand64() : 64'($urandom_range(0, 60)),
                              rand64());
            else if (roll < 65)
                send_timer_op(CMD_DEL, 4'($urandom_range(0, 15)), rand64(), 1'($urandom()),
                              rand64(), rand64());
            else if (roll < 97)
                send_timer_op(CMD_TICK, 4'($urandom()), rand64(), 1'($urandom()), rand64(),
                              ($urandom_range(0, 9) == 0) ? rand64() :
                              base + $urandom_range(0, 300));
            else
                send_timer_op(CMD_NONE, 4'($urandom()), rand64(), 1'($urandom()),
                              rand64(), rand64());
            if (k == count / 2) wait_drained();
        end
    endtask

    always @(posedge i_clk) begin
        t_timer_result exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result kind=%0d id=%0d", o_kind, o_fired_id);
                error_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_kind !== exp_r.kind) begin
                    $error("kind exp %0d got %0d", exp_r.kind, o_kind); error_count++;
                end
                if (o_fired_id !== exp_r.fired_id) begin
                    $error("fired_id exp %0d got %0d", exp_r.fired_id, o_fired_id);
                    error_count++;
                end
                if (o_status !== exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, o_status); error_count++;
                end
                if (o_program_timer !== exp_r.program_timer) begin
                    $error("program_timer exp %0d got %0d", exp_r.program_timer,
                           o_program_timer);
                    error_count++;
                end
                if (o_next_deadline !== exp_r.next_deadline) begin
                    $error("next_deadline exp %0h got %0h", exp_r.next_deadline,
                           o_next_deadline);
                    error_count++;
                end
                if (o_last !== exp_r.last) begin
                    $error("last exp %0d got %0d", exp_r.last, o_last); error_count++;
                end
            end
        end
        if (!i_rst_n || !stall_enable) i_ready <= 1'b1;
        else if ($urandom_range(0, 99) < 8) i_ready <= ~i_ready;
        else if (!i_ready && $urandom_range(0, 3) == 0) i_ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_sorted_deadline_timer_queue: errors");
            $finish;
        end
    end

    initial begin
        error_count = 0;
        idle_cycles = 0;
        stall_enable = 1'b0;
        list_count = 0;
        min_period_q = 32'd0;
        for (int k = 0; k < NUM_TIMERS; k++) begin
            slot_active_q[k] = 1'b0;
            slot_periodic_q[k] = 1'b0;
            slot_period_q[k] = 64'd0;
        end
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = 32'd0;
        i_valid = 1'b0;
        i_ready = 1'b1;
        i_cmd = CMD_NONE;
        i_timer_id = 4'd0;
        i_deadline = 64'd0;
        i_periodic = 1'b0;
        i_period = 64'd0;
        i_now = 64'd0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_min_period(32'd20);
        test_directed_ops();
        write_min_period(32'd0);
        test_full_table();
        stall_enable = 1'b1;
        write_min_period(32'hFFFF_FFFF);
        test_random_ops(15);
        write_min_period(32'd3);
        test_random_ops(30);
        write_min_period(32'($urandom_range(0, 40)));
        test_random_ops(25);
        wait_drained();
        if (error_count == 0) $display("tb_sorted_deadline_timer_queue: clean");
        else $display("tb_sorted_deadline_timer_queue: errors");
        $finish;
    end
endmodule
